[rtl/svk_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// svk_pkg
// Types and constants shared by the SVM kernel evaluator modules.
// ============================================================================
package svk_pkg;

   // Kernel modes.
   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_RBF    = 2'd1;
   localparam logic [1:0] MODE_POLY   = 2'd2;
   localparam logic [1:0] MODE_TANH   = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_GAMMA  = 2'd1;
   localparam logic [1:0] REG_BIAS   = 2'd2;
   localparam logic [1:0] REG_DEGREE = 2'd3;

   // Register reset values.
   localparam logic [1:0]  MODE_RESET   = MODE_LINEAR;
   localparam logic [31:0] GAMMA_RESET  = 32'h0100_0000;
   localparam logic [31:0] BIAS_RESET   = 32'h0000_0000;
   localparam logic [3:0]  DEGREE_RESET = 4'd2;

   // Fixed point constants.
   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam logic [62:0] HUGE_MAG     = 63'h4000_0000_0000_0000;
   localparam logic [31:0] ONE_Q16      = 32'h0001_0000;
   localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

   // Shared unit widths.
   localparam int MUL_W   = 33;
   localparam int DIV_N_W = 64;
   localparam int DIV_D_W = 34;

   // Divider request and response.
   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   // Finish sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_G_LO,
      ST_G_HI,
      ST_SCALE,
      ST_BIAS,
      ST_POW_MUL,
      ST_POW_ACC,
      ST_EXP_INIT,
      ST_EXP_LN2,
      ST_TAY_MUL,
      ST_TAY_DIV,
      ST_TAY_WAIT,
      ST_EXP_END,
      ST_TANH_DIV,
      ST_TANH_WAIT,
      ST_DONE
   } state_type;

endpackage

[rtl/svm_kernel_evaluator.sv]
`timescale 1ns / 1ps
// Non-last element pair: one pair per cycle while no finish is running.
// Last pair: the finish computes the kernel; radial basis runs a 6-step ln2 reduction,
// then the twelve Taylor terms, each waiting on the 64-step shared divider; the input
// is blocked until the result is handed over. Reset (synchronous) clears the
// accumulator, the sequencer and the output, and loads the register defaults.
// ============================================================================
// svm_kernel_evaluator
// Streams element pairs into a saturating accumulator and finishes each
// vector with a kernel function on a shared multiplier and divider.
// ============================================================================
module svm_kernel_evaluator #(
   parameter int ELEM_WIDTH = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_a,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_b,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [31:0]           rsp_kernel_value,
   output logic                         rsp_saturated,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import svk_pkg::*;

   localparam int PROD_W      = 2 * ELEM_WIDTH;
   localparam int SUM_W       = (PROD_W > ACC_WIDTH ? PROD_W : ACC_WIDTH) + 2;
   localparam int GAMMA_SHIFT = 2 * (ELEM_WIDTH - 4) + 8;

   // ---------------------------------------------------------------- registers
   logic [1:0]  mode_ff;
   logic [31:0] gamma_ff;
   logic [31:0] bias_ff;
   logic [3:0]  degree_ff;

   // Configuration writes and reads.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         gamma_ff  <= GAMMA_RESET;
         bias_ff   <= BIAS_RESET;
         degree_ff <= DEGREE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[3:2])
            REG_MODE:   mode_ff   <= csr_pwdata[1:0];
            REG_GAMMA:  gamma_ff  <= csr_pwdata;
            REG_BIAS:   bias_ff   <= csr_pwdata;
            REG_DEGREE: degree_ff <= csr_pwdata[3:0];
            default:    mode_ff   <= mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MODE:   csr_prdata = {30'd0, mode_ff};
         REG_GAMMA:  csr_prdata = gamma_ff;
         REG_BIAS:   csr_prdata = bias_ff;
         REG_DEGREE: csr_prdata = {28'd0, degree_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // ------------------------------------------------------------ accumulation
   state_type                     state_ff, state_in;
   logic signed [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic signed [ELEM_WIDTH:0]    diff;
   logic signed [ELEM_WIDTH:0]    diff_neg;
   logic [ELEM_WIDTH-1:0]         diff_mag;
   logic [PROD_W-1:0]             diff_sq;
   logic signed [PROD_W-1:0]      prod_ab;
   logic signed [SUM_W-1:0]       acc_max_w, acc_min_w, acc_w, sq_w, add_w, sum_w;
   logic signed [ACC_WIDTH-1:0]   acc_step;
   logic                          req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Product or squared difference of the pair, saturated into the accumulator.
   assign diff     = {req_elem_a[ELEM_WIDTH-1], req_elem_a}
                   - {req_elem_b[ELEM_WIDTH-1], req_elem_b};
   assign diff_neg = -diff;
   assign diff_mag = diff[ELEM_WIDTH] ? diff_neg[ELEM_WIDTH-1:0] : diff[ELEM_WIDTH-1:0];
   assign diff_sq  = diff_mag * diff_mag;
   assign prod_ab  = req_elem_a * req_elem_b;

   assign acc_max_w = {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   assign acc_min_w = ~acc_max_w;
   assign acc_w     = {{(SUM_W-ACC_WIDTH){acc_ff[ACC_WIDTH-1]}}, acc_ff};
   assign sq_w      = {{(SUM_W-PROD_W){1'b0}}, diff_sq};
   assign add_w     = (mode_ff == MODE_RBF) ? ((sq_w > acc_max_w) ? acc_max_w : sq_w)
                    : {{(SUM_W-PROD_W){prod_ab[PROD_W-1]}}, prod_ab};
   assign sum_w     = acc_w + add_w;
   assign acc_step  = (sum_w > acc_max_w) ? acc_max_w[ACC_WIDTH-1:0]
                    : (sum_w < acc_min_w) ? acc_min_w[ACC_WIDTH-1:0]
                    : sum_w[ACC_WIDTH-1:0];

   // ------------------------------------------------------- finish datapath
   logic [63:0]        mm_ff, mm_in;
   logic               xneg_ff, xneg_in;
   logic [31:0]        lo_ff, lo_in;
   logic [31:0]        carry_ff, carry_in;
   logic signed [63:0] x_ff, x_in;
   logic signed [63:0] t_ff, t_in;
   logic [31:0]        r_ff, r_in;
   logic [31:0]        mt_ff, mt_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               pneg_ff, pneg_in;
   logic [62:0]        y_ff, y_in;
   logic               tanh_ff, tanh_in;
   logic               tneg_ff, tneg_in;
   logic [31:0]        rr_ff, rr_in;
   logic [36:0]        yq_ff, yq_in;
   logic [5:0]         n_ff, n_in;
   logic [32:0]        term_ff, term_in;
   logic signed [35:0] sum_ff, sum_in;
   logic [3:0]         k_ff, k_in;
   logic [32:0]        e_ff, e_in;
   logic [31:0]        res_ff, res_in;
   logic               sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic                  mul_en;
   logic [MUL_W-1:0]      mul_a, mul_b;
   logic [2*MUL_W-1:0]    mul_p;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   logic [64:0]  acc65, acc65_neg;
   logic [63:0]  acc_mag, mm_sel;
   logic         acc_neg;
   logic [63:0]  g_hi;
   logic [95:0]  g_full, g_shift;
   logic [62:0]  g_r;
   logic [63:0]  g_r64, g_r64_neg;
   logic [63:0]  t_neg64, t_mag;
   logic [62:0]  pow_round;
   logic [46:0]  pow_r;
   logic [36:0]  ln2_shift, ln2_rem;
   logic         ln2_fit;
   logic [5:0]   ln2_bit;
   logic [34:0]  exp_s;
   logic [63:0]  exp_s64, exp_e;
   logic [32:0]  tanh_num;
   logic [33:0]  tanh_den;
   logic [31:0]  pow_r32_neg, tanh_q_neg;

   // Magnitude of the accumulator for the gamma scaling.
   assign acc65     = {{(65-ACC_WIDTH){acc_ff[ACC_WIDTH-1]}}, acc_ff};
   assign acc65_neg = -acc65;
   assign acc_neg   = acc_ff[ACC_WIDTH-1];
   assign acc_mag   = acc_neg ? acc65_neg[63:0] : acc65[63:0];
   assign mm_sel    = (mode_ff == MODE_RBF && acc_neg) ? 64'd0 : acc_mag;

   // Assembly of the 96-bit gamma product, truncation and cap.
   assign g_hi      = mul_p[63:0] + {32'd0, carry_ff};
   assign g_full    = {g_hi, lo_ff};
   assign g_shift   = g_full >> GAMMA_SHIFT;
   assign g_r       = (g_shift > {33'd0, HUGE_MAG}) ? HUGE_MAG : g_shift[62:0];
   assign g_r64     = {1'b0, g_r};
   assign g_r64_neg = -g_r64;

   // Magnitude of the biased value.
   assign t_neg64 = -t_ff;
   assign t_mag   = t_ff[63] ? t_neg64 : t_ff;

   // Power step, rounded to nearest on the magnitude.
   assign pow_round   = mul_p[62:0] + 63'h8000;
   assign pow_r       = pow_round[62:16];
   assign pow_r32_neg = -pow_r[31:0];

   // Reduction by ln2: one compare and subtract of a shifted ln2 per step,
   // from the 32x multiple down to 1x; the count is below 64.
   assign ln2_shift = {5'd0, LN2_Q32} << k_ff[2:0];
   assign ln2_fit   = yq_ff >= ln2_shift;
   assign ln2_rem   = ln2_fit ? yq_ff - ln2_shift : yq_ff;
   assign ln2_bit   = {5'd0, ln2_fit} << k_ff[2:0];

   // Final shift of the exp series by the ln2 count, rounded to nearest.
   assign exp_s   = sum_ff[35] ? 35'd0 : sum_ff[34:0];
   assign exp_s64 = {29'd0, exp_s};
   assign exp_e   = (n_ff == 6'd0) ? exp_s64
                  : (exp_s64 + (64'd1 << (n_ff - 6'd1))) >> n_ff;

   // Tanh operands.
   assign tanh_num   = 33'h1_0000_0000 - e_ff;
   assign tanh_den   = 34'h1_0000_0000 + {1'b0, e_ff};
   assign tanh_q_neg = -div_rsp.quotient[31:0];

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      mm_in        = mm_ff;
      xneg_in      = xneg_ff;
      lo_in        = lo_ff;
      carry_in     = carry_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      mt_in        = mt_ff;
      cnt_in       = cnt_ff;
      pneg_in      = pneg_ff;
      y_in         = y_ff;
      tanh_in      = tanh_ff;
      tneg_in      = tneg_ff;
      rr_in        = rr_ff;
      yq_in        = yq_ff;
      n_in         = n_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      res_in       = res_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in = acc_step;
               if (req_last) begin
                  state_in = ST_G_LO;
               end
            end
         end

         // Gamma scaling: low half of the magnitude first.
         ST_G_LO: begin
            mm_in    = mm_sel;
            xneg_in  = (mode_ff != MODE_RBF) && acc_neg;
            acc_in   = '0;
            mul_en   = 1'b1;
            mul_a    = {1'b0, mm_sel[31:0]};
            mul_b    = {1'b0, gamma_ff};
            state_in = ST_G_HI;
         end

         ST_G_HI: begin
            lo_in    = mul_p[31:0];
            carry_in = mul_p[63:32];
            mul_en   = 1'b1;
            mul_a    = {1'b0, mm_ff[63:32]};
            mul_b    = {1'b0, gamma_ff};
            state_in = ST_SCALE;
         end

         ST_SCALE: begin
            x_in     = xneg_ff ? g_r64_neg : g_r64;
            y_in     = g_r;
            state_in = ST_BIAS;
         end

         // Branch on the mode.
         ST_BIAS: begin
            t_in = x_ff + {{32{bias_ff[31]}}, bias_ff};
            case (mode_ff)
               MODE_LINEAR: begin
                  sat_in   = 1'b0;
                  res_in   = x_ff[31:0];
                  if (x_ff > 64'sh0000_0000_7FFF_FFFF) begin
                     sat_in = 1'b1;
                     res_in = 32'h7FFF_FFFF;
                  end else if (x_ff < -64'sh0000_0000_8000_0000) begin
                     sat_in = 1'b1;
                     res_in = 32'h8000_0000;
                  end
                  state_in = ST_DONE;
               end
               MODE_RBF: begin
                  tanh_in  = 1'b0;
                  state_in = ST_EXP_INIT;
               end
               default: begin
                  state_in = (mode_ff == MODE_POLY) ? ST_POW_MUL : ST_EXP_INIT;
               end
            endcase
         end

         // Power setup happens on the first multiply pass.
         ST_POW_MUL: begin
            if (cnt_ff == 4'd0) begin
               pneg_in = t_ff[63] && degree_ff[0];
               if (degree_ff == 4'd0) begin
                  res_in   = ONE_Q16;
                  sat_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (t_mag > 64'h8000_0000) begin
                  sat_in   = 1'b1;
                  res_in   = (t_ff[63] && degree_ff[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  state_in = ST_DONE;
               end else begin
                  mt_in    = t_mag[31:0];
                  cnt_in   = degree_ff;
                  mul_en   = 1'b1;
                  mul_a    = {1'b0, ONE_Q16};
                  mul_b    = {1'b0, t_mag[31:0]};
                  state_in = ST_POW_ACC;
               end
            end else begin
               mul_en   = 1'b1;
               mul_a    = {1'b0, r_ff};
               mul_b    = {1'b0, mt_ff};
               state_in = ST_POW_ACC;
            end
         end

         ST_POW_ACC: begin
            if (pow_r > 47'h8000_0000) begin
               sat_in   = 1'b1;
               res_in   = pneg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
               cnt_in   = 4'd0;
               state_in = ST_DONE;
            end else if (cnt_ff == 4'd1) begin
               cnt_in = 4'd0;
               if (!pneg_ff && pow_r > 47'h7FFF_FFFF) begin
                  sat_in = 1'b1;
                  res_in = 32'h7FFF_FFFF;
               end else begin
                  sat_in = 1'b0;
                  res_in = pneg_ff ? pow_r32_neg : pow_r[31:0];
               end
               state_in = ST_DONE;
            end else begin
               r_in     = pow_r[31:0];
               cnt_in   = cnt_ff - 4'd1;
               state_in = ST_POW_MUL;
            end
         end

         // Exp of minus y: tanh first forms y from the biased value.
         ST_EXP_INIT: begin
            if (mode_ff == MODE_TANH && !tanh_ff) begin
               tanh_in = 1'b1;
               tneg_in = t_ff[63];
               y_in    = (t_mag >= 64'h10_0000) ? 63'h20_0000 : {t_mag[61:0], 1'b0};
            end else if (y_ff >= 63'h20_0000) begin
               sum_in   = '0;
               n_in     = '0;
               state_in = ST_EXP_END;
            end else begin
               yq_in    = {y_ff[20:0], 16'd0};
               n_in     = '0;
               k_in     = 4'd5;
               state_in = ST_EXP_LN2;
            end
         end

         // One quotient bit of the ln2 count per cycle, highest bit first.
         ST_EXP_LN2: begin
            yq_in = ln2_rem;
            n_in  = n_ff | ln2_bit;
            if (k_ff == 4'd0) begin
               rr_in    = ln2_rem[31:0];
               term_in  = 33'h1_0000_0000;
               sum_in   = 36'sh1_0000_0000;
               k_in     = 4'd1;
               state_in = ST_TAY_MUL;
            end else begin
               k_in = k_ff - 4'd1;
            end
         end

         // Taylor series: one multiply and one divide per term.
         ST_TAY_MUL: begin
            mul_en   = 1'b1;
            mul_a    = term_ff;
            mul_b    = {1'b0, rr_ff};
            state_in = ST_TAY_DIV;
         end

         ST_TAY_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {30'd0, mul_p[65:32]};
            div_req.divisor  = {30'd0, k_ff};
            state_in         = ST_TAY_WAIT;
         end

         ST_TAY_WAIT: begin
            if (div_rsp.done) begin
               term_in = div_rsp.quotient[32:0];
               sum_in  = k_ff[0] ? sum_ff - {3'd0, div_rsp.quotient[32:0]}
                                 : sum_ff + {3'd0, div_rsp.quotient[32:0]};
               if (k_ff == TAYLOR_TERMS) begin
                  state_in = ST_EXP_END;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = ST_TAY_MUL;
               end
            end
         end

         ST_EXP_END: begin
            e_in = exp_e[32:0];
            if (tanh_ff) begin
               state_in = ST_TANH_DIV;
            end else begin
               res_in   = {15'd0, exp_e[32:16] + {16'd0, exp_e[15]}};
               sat_in   = 1'b0;
               state_in = ST_DONE;
            end
         end

         ST_TANH_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {15'd0, tanh_num, 16'd0} + {31'd0, tanh_den[33:1]};
            div_req.divisor  = tanh_den;
            state_in         = ST_TANH_WAIT;
         end

         ST_TANH_WAIT: begin
            if (div_rsp.done) begin
               res_in   = tneg_ff ? tanh_q_neg : div_rsp.quotient[31:0];
               sat_in   = 1'b0;
               state_in = ST_DONE;
            end
         end

         // Hand the item to the output register once it is free.
         ST_DONE: begin
            tanh_in = 1'b0;
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         tanh_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         tanh_ff      <= tanh_in;
      end
      mm_ff        <= mm_in;
      xneg_ff      <= xneg_in;
      lo_ff        <= lo_in;
      carry_ff     <= carry_in;
      x_ff         <= x_in;
      t_ff         <= t_in;
      r_ff         <= r_in;
      mt_ff        <= mt_in;
      pneg_ff      <= pneg_in;
      y_ff         <= y_in;
      tneg_ff      <= tneg_in;
      rr_ff        <= rr_in;
      yq_ff        <= yq_in;
      n_ff         <= n_in;
      term_ff      <= term_in;
      sum_ff       <= sum_in;
      k_ff         <= k_in;
      e_ff         <= e_in;
      res_ff       <= res_in;
      sat_ff       <= sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // Shared arithmetic units.
   svk_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   svk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

[rtl/svk_mul.sv]
`timescale 1ns / 1ps
// ============================================================================
// svk_mul
// Shared unsigned multiplier with a registered product that holds its value.
// ============================================================================
module svk_mul (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [svk_pkg::MUL_W-1:0]     op_a,
   input  logic [svk_pkg::MUL_W-1:0]     op_b,
   output logic [2*svk_pkg::MUL_W-1:0]   product
);
   import svk_pkg::*;

   logic [2*MUL_W-1:0] product_ff;

   // The product is loaded only when a new operation is issued.
   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= op_a * op_b;
      end
   end

   assign product = product_ff;

endmodule

[rtl/svk_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// svk_div
// Shared restoring divider, one quotient bit per cycle.
// ============================================================================
module svk_div (
   input  logic                 clock,
   input  logic                 reset,
   input  svk_pkg::div_req_type div_req,
   output svk_pkg::div_rsp_type div_rsp
);
   import svk_pkg::*;

   logic [DIV_N_W-1:0] dvd_ff, dvd_in;
   logic [DIV_D_W-1:0] dvs_ff, dvs_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   // One restoring step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, dvd_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_N_W-2:0], fits};
         rem_in = fits ? DIV_D_W'(trial - {1'b0, dvs_ff}) : trial[DIV_D_W-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   // The quotient accumulates in the dividend register.
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

[rtl/svk_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// svk_checker
// Port-level checks on the SVM kernel evaluator, bound to the top level.
// ============================================================================
module svk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_kernel_value,
   input logic        rsp_saturated
);

   // A held result keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kernel_value))
      else $error("held result changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The last pair of a vector starts the finish, which blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> req_stall)
      else $error("input not blocked during finish");

   // A clipped result sits at one end of the range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_kernel_value == 32'h7FFF_FFFF || rsp_kernel_value == 32'h8000_0000))
      else $error("saturated result not at a range limit");

endmodule

bind svm_kernel_evaluator svk_checker u_svk_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kernel_value (rsp_kernel_value),
   .rsp_saturated    (rsp_saturated)
);
